// File: sv/ste_pkg.sv
// types, codes and defaults shared by the sorted table engine
package ste_pkg;

  localparam int unsigned DefTableDepth = 64;
  localparam int unsigned DefValueWidth = 32;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_SEARCH = 3'd2,
    ACT_FIRST  = 3'd3,
    ACT_NEXT   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_STEP   = 2'd1,
    S_EVAL   = 2'd2,
    S_FINISH = 2'd3
  } seq_state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  found_index;
    logic [31:0] read_value;
    logic [6:0]  entry_count;
    logic        is_empty;
  } out_item_t;

endpackage

// File: sv/sorted_table_engine.sv
// sorted table engine: commands walk the table one entry at a time through one comparator
// each visited entry goes through the step state (registered read), then the eval state (compare and write back)
// first and next read a single entry; refused and unused commands go straight to finish;
// a new input transfer is taken only in the idle state, once the result of the last
// command is loaded, so one command is handled at a time; a stalled
// result holds the sequencer; reset clears count, cursor and sequencer, not the memory
module sorted_table_engine #(
  parameter int unsigned TABLE_DEPTH = ste_pkg::DefTableDepth,
  parameter int unsigned VALUE_WIDTH = ste_pkg::DefValueWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ste_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ste_pkg::out_item_t  out_data_o
);
  import ste_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam logic [CntW-1:0] DepthC = CntW'(TABLE_DEPTH);
  localparam logic [CntW-1:0] OneC = CntW'(1);

  // entry memory, one write and one registered read per cycle
  logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;
  logic                   mem_we;
  logic [IdxW-1:0]        mem_waddr, mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;

  seq_state_e state_q, state_d;
  logic [2:0] act_q, act_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [CntW-1:0] idx_q, idx_d, kept_q, kept_d, count_q, count_d, cursor_q, cursor_d;
  logic [CntW-1:0] idx_m1;
  status_e stat_q, stat_d;
  logic [IdxW-1:0] fidx_q, fidx_d;
  logic [VALUE_WIDTH-1:0] rval_q, rval_d;
  out_item_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic [63:0] fidx_wide, rval_wide, count_wide;

  assign idx_m1 = idx_q - OneC;
  assign fidx_wide = 64'(fidx_q);
  assign rval_wide = 64'(rval_q);
  assign count_wide = 64'(count_q);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    val_q  <= val_d;
    idx_q  <= idx_d;
    kept_q <= kept_d;
    stat_q <= stat_d;
    fidx_q <= fidx_d;
    rval_q <= rval_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    val_d       = val_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    stat_d      = stat_q;
    fidx_d      = fidx_q;
    rval_d      = rval_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[IdxW-1:0];
    mem_wdata   = val_q;
    mem_raddr   = idx_q[IdxW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d  = in_data_i.action;
          val_d  = VALUE_WIDTH'(in_data_i.item_value);
          idx_d  = '0;
          kept_d = '0;
          stat_d = ST_OK;
          fidx_d = '0;
          rval_d = '0;
          state_d = S_STEP;
          case (in_data_i.action)
            ACT_INSERT: begin
              if (count_q >= DepthC) begin
                stat_d  = ST_FULL;
                state_d = S_FINISH;
              end else begin
                idx_d = count_q;
              end
            end
            ACT_REMOVE: ;
            ACT_SEARCH: stat_d = ST_NOT_FOUND;
            ACT_FIRST: begin
              if (count_q == '0) begin
                stat_d   = ST_EMPTY;
                cursor_d = '0;
                state_d  = S_FINISH;
              end
            end
            ACT_NEXT: begin
              if (cursor_q >= count_q) begin
                stat_d  = ST_EMPTY;
                state_d = S_FINISH;
              end else begin
                idx_d = cursor_q;
              end
            end
            default: state_d = S_FINISH;
          endcase
        end
      end

      S_STEP: begin
        state_d = S_EVAL;
        case (act_q)
          ACT_INSERT: begin
            if (idx_q == '0) begin
              // reached the bottom: the new value becomes the smallest entry
              mem_we    = 1'b1;
              mem_waddr = '0;
              count_d   = count_q + OneC;
              state_d   = S_FINISH;
            end else begin
              mem_raddr = idx_m1[IdxW-1:0];
            end
          end
          ACT_REMOVE: begin
            if (idx_q == count_q) begin
              stat_d  = (kept_q == count_q) ? ST_NOT_FOUND : ST_OK;
              count_d = kept_q;
              state_d = S_FINISH;
            end
          end
          ACT_SEARCH: begin
            if (idx_q == count_q) begin
              state_d = S_FINISH;
            end
          end
          default: ;
        endcase
      end

      S_EVAL: begin
        state_d = S_STEP;
        case (act_q)
          ACT_INSERT: begin
            mem_we = 1'b1;
            if (rdata_q > val_q) begin
              // shift the larger entry up into the hole
              mem_wdata = rdata_q;
              idx_d     = idx_m1;
            end else begin
              count_d = count_q + OneC;
              state_d = S_FINISH;
            end
          end
          ACT_REMOVE: begin
            if (rdata_q != val_q) begin
              mem_we    = 1'b1;
              mem_waddr = kept_q[IdxW-1:0];
              mem_wdata = rdata_q;
              kept_d    = kept_q + OneC;
            end
            idx_d = idx_q + OneC;
          end
          ACT_SEARCH: begin
            if (rdata_q == val_q) begin
              stat_d  = ST_OK;
              fidx_d  = idx_q[IdxW-1:0];
              state_d = S_FINISH;
            end else begin
              idx_d = idx_q + OneC;
            end
          end
          default: begin
            // first and next: read the entry at the cursor and advance it
            rval_d   = rdata_q;
            cursor_d = idx_q + OneC;
            state_d  = S_FINISH;
          end
        endcase
      end

      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.status      = stat_q;
          out_d.found_index = fidx_wide[5:0];
          out_d.read_value  = rval_wide[31:0];
          out_d.entry_count = count_wide[6:0];
          out_d.is_empty    = (count_q == '0);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= DepthC) && (cursor_q <= DepthC))
    else $error("count or cursor beyond table depth");

  a_eval_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> ($past(state_q) == S_STEP))
    else $error("compare without a preceding memory read");

  a_insert_hole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && act_q == ACT_INSERT) |-> (idx_q != '0 && idx_q < DepthC))
    else $error("insert hole out of range");

  // the count only shrinks on the way to finish, so check while walking
  a_remove_compact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_STEP || state_q == S_EVAL) && act_q == ACT_REMOVE)
    |-> (kept_q <= idx_q && idx_q <= count_q))
    else $error("remove compaction overtook its read pointer");

endmodule

// File: tb/sv/sorted_table_engine_tb.sv
// self-checking testbench for the sorted table engine: directed commands, then random episodes
module sorted_table_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ste_pkg::*;

  // action codes the block leaves unused
  localparam logic [2:0] ActSpareLo = 3'd5;
  localparam logic [2:0] ActSpareHi = 3'd7;
  localparam int RandItems = 1050;
  localparam int SettleCycles = 4 * DefTableDepth;

  typedef struct {
    in_item_t  cmd;
    bit        fixed;
    out_item_t want;
  } script_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  // mirror of the table contents, kept in ascending order
  logic [31:0] held_vals[$];
  int unsigned scan_cursor = 0;
  out_item_t   due_replies[$];
  script_row_t script_rows[$];
  logic [31:0] value_pool[6];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int failures = 0;
  int cmds_sent = 0;
  int replies_seen = 0;
  int rand_items = 0;
  int full_hits = 0;
  int past_end_hits = 0;
  int peak_index = 0;

  sorted_table_engine u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // what the table answers to one command, updating the mirror
  function automatic out_item_t table_reply(input in_item_t cmd);
    out_item_t   r;
    logic [31:0] kept[$];
    int          pos;
    r = '0;
    r.status = ST_OK;
    case (cmd.action)
      ACT_INSERT: begin
        if (held_vals.size() >= DefTableDepth) begin
          r.status = ST_FULL;
          full_hits++;
        end else begin
          pos = held_vals.size();
          // equal entries stay ahead of the new one
          for (int i = 0; i < held_vals.size(); i++) begin
            if (held_vals[i] > cmd.item_value) begin
              pos = i;
              break;
            end
          end
          held_vals.insert(pos, cmd.item_value);
        end
      end
      ACT_REMOVE: begin
        foreach (held_vals[i]) if (held_vals[i] != cmd.item_value) kept = {kept, held_vals[i]};
        if (kept.size() == held_vals.size()) r.status = ST_NOT_FOUND;
        held_vals = kept;
      end
      ACT_SEARCH: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < held_vals.size(); i++) begin
          if (held_vals[i] == cmd.item_value) begin
            r.status = ST_OK;
            r.found_index = 6'(i);
            if (i > peak_index) peak_index = i;
            break;
          end
        end
      end
      ACT_FIRST: begin
        if (held_vals.size() == 0) begin
          r.status = ST_EMPTY;
          scan_cursor = 0;
        end else begin
          r.read_value = held_vals[0];
          scan_cursor = 1;
        end
      end
      ACT_NEXT: begin
        if (scan_cursor >= held_vals.size()) begin
          r.status = ST_EMPTY;
          past_end_hits++;
        end else begin
          r.read_value = held_vals[scan_cursor];
          scan_cursor++;
        end
      end
      default: ;
    endcase
    r.entry_count = 7'(held_vals.size());
    r.is_empty = (held_vals.size() == 0);
    return r;
  endfunction

  function automatic string fmt_reply(input out_item_t r);
    return $sformatf("status %0d index %0d value %h count %0d empty %0b",
                     r.status, r.found_index, r.read_value, r.entry_count, r.is_empty);
  endfunction

  function automatic logic [31:0] pick_held();
    if (held_vals.size() == 0) return $urandom;
    return held_vals[$urandom_range(held_vals.size() - 1)];
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return value_pool[$urandom_range(5)];
      4, 5:       return pick_held();
      9:          return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default:    return $urandom;
    endcase
  endfunction

  task automatic add_row(input logic [2:0] act, input logic [31:0] val, input bit fixed,
                         input status_e st, input int cnt);
    script_row_t row;
    row.cmd.action = act;
    row.cmd.item_value = val;
    row.fixed = fixed;
    row.want = '0;
    row.want.status = st;
    row.want.entry_count = 7'(cnt);
    row.want.is_empty = (cnt == 0);
    script_rows.insert(script_rows.size(), row);
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_cmd(input in_item_t cmd, input bit fixed, input out_item_t want);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (in_stall_o);
    predicted = table_reply(cmd);
    due_replies.insert(due_replies.size(), fixed ? want : predicted);
    cmds_sent++;
    @(negedge clk_i);
  endtask

  task automatic issue(input logic [2:0] act, input logic [31:0] val);
    in_item_t cmd;
    cmd.action = act;
    cmd.item_value = val;
    send_cmd(cmd, 1'b0, '0);
    if (act <= ACT_NEXT) rand_items++;
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (due_replies.size() != 0);
  endtask

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      replies_seen++;
      if (due_replies.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result: %s", fmt_reply(out_data_o));
      end else begin
        want = due_replies.pop_front();
        if (out_data_o.status !== want.status || out_data_o.found_index !== want.found_index
            || out_data_o.read_value !== want.read_value
            || out_data_o.entry_count !== want.entry_count
            || out_data_o.is_empty !== want.is_empty) begin
          failures++;
          if (failures <= 10) begin
            $display("mismatch on result %0d", replies_seen);
            $display("  expected %s", fmt_reply(want));
            $display("  actual   %s", fmt_reply(out_data_o));
          end
        end
      end
    end
  end

  initial begin
    int n;
    int r;
    int phase;
    phase = 0;
    send_idle_pct = 17;
    recv_stall_pct = 60;

    // fresh table, extremes, duplicates, cursor past end, spare codes
    add_row(ACT_NEXT,   32'h5A5A_A5A5, 1, ST_EMPTY,     0);
    add_row(ACT_FIRST,  32'hA5A5_5A5A, 1, ST_EMPTY,     0);
    add_row(ACT_SEARCH, 32'h0000_0005, 1, ST_NOT_FOUND, 0);
    add_row(ACT_REMOVE, 32'h0000_0005, 1, ST_NOT_FOUND, 0);
    add_row(ActSpareHi, 32'hFFFF_FFFF, 1, ST_OK,        0);
    add_row(ACT_INSERT, 32'hFFFF_FFFF, 1, ST_OK,        1);
    add_row(ACT_INSERT, 32'h0000_0000, 1, ST_OK,        2);
    add_row(ACT_INSERT, 32'h8000_0000, 1, ST_OK,        3);
    add_row(ACT_INSERT, 32'h8000_0000, 1, ST_OK,        4);
    add_row(ACT_NEXT,   32'hFFFF_FFFF, 0, ST_OK,        0);
    add_row(ACT_SEARCH, 32'h8000_0000, 0, ST_OK,        0);
    add_row(ACT_SEARCH, 32'hFFFF_FFFF, 0, ST_OK,        0);
    add_row(ACT_FIRST,  32'h1234_5678, 0, ST_OK,        0);
    add_row(ACT_NEXT,   32'h0000_0000, 0, ST_OK,        0);
    add_row(ACT_NEXT,   32'h0000_0000, 0, ST_OK,        0);
    add_row(ACT_NEXT,   32'h0000_0000, 0, ST_OK,        0);
    add_row(ACT_NEXT,   32'h0000_0000, 1, ST_EMPTY,     4);
    add_row(ActSpareLo, 32'h8000_0000, 1, ST_OK,        4);
    add_row(ACT_REMOVE, 32'h8000_0000, 1, ST_OK,        2);
    add_row(ACT_NEXT,   32'h0000_0000, 1, ST_EMPTY,     2);
    add_row(ACT_SEARCH, 32'h8000_0000, 1, ST_NOT_FOUND, 2);
    add_row(ACT_FIRST,  32'hFFFF_FFFF, 0, ST_OK,        0);
    add_row(ACT_REMOVE, 32'h0000_0000, 1, ST_OK,        1);
    add_row(ACT_NEXT,   32'h0000_0000, 1, ST_EMPTY,     1);
    add_row(ACT_REMOVE, 32'hFFFF_FFFF, 1, ST_OK,        0);

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script_rows[i]) send_cmd(script_rows[i].cmd, script_rows[i].fixed,
                                      script_rows[i].want);

    foreach (value_pool[k]) value_pool[k] = $urandom;

    while (rand_items < RandItems) begin
      if (phase == 0 && rand_items >= RandItems / 3) begin
        hold_until_drained();
        send_idle_pct = 60;
        recv_stall_pct = 17;
        phase = 1;
      end else if (phase == 1 && rand_items >= 2 * RandItems / 3) begin
        hold_until_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        phase = 2;
      end
      case ($urandom_range(9))
        // fill: mostly inserts, runs into a full table
        0, 1, 2: begin
          n = $urandom_range(30, 90);
          repeat (n) begin
            r = $urandom_range(99);
            if (r < 85) issue(ACT_INSERT, pick_value());
            else if (r < 95) issue(ACT_SEARCH, pick_value());
            else issue(ACT_REMOVE, pick_value());
          end
        end
        // drain: mostly removes and searches of held values, with some inserts
        3, 4: begin
          n = $urandom_range(20, 70);
          repeat (n) begin
            r = $urandom_range(99);
            if (r < 55) issue(ACT_REMOVE, pick_held());
            else if (r < 65) issue(ACT_REMOVE, pick_value());
            else if (r < 90) issue(ACT_SEARCH, pick_held());
            else issue(ACT_INSERT, pick_value());
          end
        end
        // scan: first, then mostly next, about as many as the entries held
        5, 6: begin
          issue(ACT_FIRST, $urandom);
          n = held_vals.size() + $urandom_range(0, 2);
          repeat (n) begin
            if ($urandom_range(99) < 90) issue(ACT_NEXT, $urandom);
            else issue($urandom_range(1) ? ACT_INSERT : ACT_REMOVE, pick_value());
          end
        end
        7, 8: begin
          n = $urandom_range(10, 40);
          repeat (n) issue(3'($urandom_range(ACT_INSERT, ACT_NEXT)), pick_value());
        end
        default: begin
          n = $urandom_range(3, 10);
          repeat (n) issue(3'($urandom_range(ActSpareHi)), $urandom);
        end
      endcase
    end

    in_valid_i <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("ran %0d commands (%0d from the directed table), checked %0d results, %0d bad",
             cmds_sent, script_rows.size(), replies_seen, failures);
    $display("inserts refused when full: %0d, reads past end: %0d, deepest search hit: %0d",
             full_hits, past_end_hits, peak_index);
    if (failures == 0) begin
      $display("sorted_table_engine_tb: PASS");
    end else begin
      $display("sorted_table_engine_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("sorted_table_engine_tb: FAIL");
    $finish;
  end

endmodule

// File: sorted_table_engine.f
sv/ste_pkg.sv
sv/sorted_table_engine.sv
tb/sv/sorted_table_engine_tb.sv
